// ===== design/bmq_pkg.sv =====
package bmq_pkg;

  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_WAIT_DEPTH  = 32;
  localparam int DEF_ITEM_BYTES  = 8;

  localparam int MSG_W  = 64;
  localparam int TASK_W = 5;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] ITEM_BYTES_RESET = 4'd8;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_BLOCKED   = 2'd1;
  localparam logic [1:0] STATUS_WAIT_FULL = 2'd2;

  localparam logic OP_SEND    = 1'b0;
  localparam logic OP_RECEIVE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Keep the low n bytes of a 64-bit message.
  function automatic logic [MSG_W-1:0] byte_mask(input logic [CFG_W-1:0] n);
    logic [MSG_W-1:0] m;
    m = '0;
    for (int i = 0; i < MSG_W / 8; i++) begin
      m[i*8 +: 8] = {8{(CFG_W'(i) < n)}};
    end
    return m;
  endfunction

endpackage

// ===== design/bmq_ram.sv =====
module bmq_ram
  import bmq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/bmq_ptr.sv =====
module bmq_ptr
  import bmq_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          pop,
  output logic [PW-1:0] head,
  output logic [PW-1:0] tail,
  output logic          full,
  output logic          empty
);

  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == PW'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (pop) begin
      head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign head  = head_r;
  assign tail  = tail_r;
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

endmodule

// ===== design/blocking_message_queue_unit.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_opcode, in_task_id, in_message_in
// out_      output     out_valid/out_stall out_status, out_message_out, out_woke_valid,
//                                          out_woke_task
// cfg_      input      cfg_valid/cfg_ready cfg_item_bytes
//
// Each request has a transfer cycle, which issues the reads of the message store and
// of the wait-list memory, and an execute cycle, which uses the read data, writes back
// and loads the result register. One request is in flight at a time.
// A stalled result holds the execute cycle until the result register frees up.
// Synchronous active-low reset clears pointers, counts and item_bytes (to 8); the
// memories need no clearing because counts guard every read.
module blocking_message_queue_unit
  import bmq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int WAIT_DEPTH  = DEF_WAIT_DEPTH,
  parameter int ITEM_BYTES  = DEF_ITEM_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [TASK_W-1:0] in_task_id,
  input  logic [MSG_W-1:0]  in_message_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [MSG_W-1:0]  out_message_out,
  output logic              out_woke_valid,
  output logic [TASK_W-1:0] out_woke_task,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_item_bytes
);

  localparam int QPW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int WPW    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WAW    = $clog2(2 * WAIT_DEPTH);
  localparam int STORE_W = ITEM_BYTES * 8;

  // Wait-list memory holds the sender list in the low half, receivers in the high half
  localparam logic [WAW-1:0] RCV_BASE = WAW'(WAIT_DEPTH);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] item_bytes_r;
  logic [CFG_W-1:0] eff_bytes;
  logic [MSG_W-1:0] mask;

  // captured request
  logic              op_r;
  logic [TASK_W-1:0] task_r;
  logic [MSG_W-1:0]  msg_r;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [MSG_W-1:0]  out_message_r;
  logic              out_woke_valid_r;
  logic [TASK_W-1:0] out_woke_task_r;

  logic in_xfer;
  logic exec_go;

  // pointer control
  logic q_push, q_pop, s_push, s_pop, r_push, r_pop;
  logic [QPW-1:0] q_head, q_tail;
  logic [WPW-1:0] s_head, s_tail, r_head, r_tail;
  logic q_full, q_empty, s_full, s_empty, r_full, r_empty;

  // memory ports
  logic [STORE_W-1:0] q_rdata, q_wdata;
  logic               w_we;
  logic [WAW-1:0]     w_waddr, w_raddr;
  logic [TASK_W-1:0]  w_rdata;

  // result of the execute cycle
  logic [1:0]        res_status;
  logic [MSG_W-1:0]  res_message;
  logic              res_woke_valid;
  logic [TASK_W-1:0] res_woke_task;

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign exec_go   = (state_r == ST_EXEC) && !(out_valid_r && out_stall);
  assign cfg_ready = 1'b1;

  // clamp byte count: zero acts as one, above the stored width acts as the width
  always_comb begin
    if (item_bytes_r == '0) begin
      eff_bytes = CFG_W'(1);
    end else if (item_bytes_r > CFG_W'(ITEM_BYTES)) begin
      eff_bytes = CFG_W'(ITEM_BYTES);
    end else begin
      eff_bytes = item_bytes_r;
    end
  end

  assign mask = byte_mask(eff_bytes);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_bytes_r <= ITEM_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      item_bytes_r <= cfg_item_bytes;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the request payload for the execute cycle
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_opcode;
      task_r <= in_task_id;
      msg_r  <= in_message_in;
    end
  end

  // Read the head of the list a request may wake: a send wakes a receiver, a
  // receive wakes a sender. The message store is always read at its head.
  assign w_raddr = (in_opcode == OP_SEND) ? RCV_BASE + WAW'(r_head) : WAW'(s_head);

  always_comb begin
    q_push         = 1'b0;
    q_pop          = 1'b0;
    s_push         = 1'b0;
    s_pop          = 1'b0;
    r_push         = 1'b0;
    r_pop          = 1'b0;
    w_we           = 1'b0;
    w_waddr        = WAW'(s_tail);
    res_status     = STATUS_DONE;
    res_message    = '0;
    res_woke_valid = 1'b0;
    res_woke_task  = '0;
    if (op_r == OP_SEND) begin
      if (q_full) begin
        // queue full: park the sender
        if (s_full) begin
          res_status = STATUS_WAIT_FULL;
        end else begin
          res_status = STATUS_BLOCKED;
          s_push     = exec_go;
          w_we       = exec_go;
        end
      end else begin
        q_push = exec_go;
        if (!r_empty) begin
          r_pop          = exec_go;
          res_woke_valid = 1'b1;
          res_woke_task  = w_rdata;
        end
      end
    end else begin
      if (q_empty) begin
        // queue empty: park the receiver
        w_waddr = RCV_BASE + WAW'(r_tail);
        if (r_full) begin
          res_status = STATUS_WAIT_FULL;
        end else begin
          res_status = STATUS_BLOCKED;
          r_push     = exec_go;
          w_we       = exec_go;
        end
      end else begin
        q_pop       = exec_go;
        res_message = MSG_W'(q_rdata) & mask;
        if (!s_empty) begin
          s_pop          = exec_go;
          res_woke_valid = 1'b1;
          res_woke_task  = w_rdata;
        end
      end
    end
  end

  // drop the bytes above the byte count before storing
  assign q_wdata = STORE_W'(msg_r & mask);

  bmq_ptr #(.DEPTH(QUEUE_DEPTH)) u_q_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .tail  (q_tail),
    .full  (q_full),
    .empty (q_empty)
  );

  bmq_ptr #(.DEPTH(WAIT_DEPTH)) u_s_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s_push),
    .pop   (s_pop),
    .head  (s_head),
    .tail  (s_tail),
    .full  (s_full),
    .empty (s_empty)
  );

  bmq_ptr #(.DEPTH(WAIT_DEPTH)) u_r_ptr (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .pop   (r_pop),
    .head  (r_head),
    .tail  (r_tail),
    .full  (r_full),
    .empty (r_empty)
  );

  bmq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(STORE_W), .AW(QPW)) u_msg_ram (
    .clk   (clk),
    .we    (q_push),
    .waddr (q_tail),
    .wdata (q_wdata),
    .re    (in_xfer),
    .raddr (q_head),
    .rdata (q_rdata)
  );

  bmq_ram #(.DEPTH(2 * WAIT_DEPTH), .WIDTH(TASK_W), .AW(WAW)) u_wait_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (task_r),
    .re    (in_xfer),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  // result register: load on execute, clear once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_status_r     <= res_status;
      out_message_r    <= res_message;
      out_woke_valid_r <= res_woke_valid;
      out_woke_task_r  <= res_woke_task;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_message_out = out_message_r;
  assign out_woke_valid  = out_woke_valid_r;
  assign out_woke_task   = out_woke_task_r;

endmodule

// ===== design/bmq_checker.sv =====
module bmq_checker
  import bmq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_status,
  input logic [MSG_W-1:0]  out_message_out,
  input logic              out_woke_valid,
  input logic [TASK_W-1:0] out_woke_task
);

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one request in flight: no transfer straight after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request is in flight");

  // blocked or failed request returns nothing and wakes nobody
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STATUS_DONE) |->
      (out_message_out == '0 && !out_woke_valid))
    else $error("non-done result carries a message or a wake");

  // woken task number is zero when nobody was woken
  a_woke_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_woke_valid) |-> (out_woke_task == '0))
    else $error("woke_task set without woke_valid");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_message_out) &&
       $stable(out_woke_valid) && $stable(out_woke_task)))
    else $error("stalled result changed");

endmodule

bind blocking_message_queue_unit bmq_checker u_bmq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_message_out (out_message_out),
  .out_woke_valid  (out_woke_valid),
  .out_woke_task   (out_woke_task)
);
